@@ design/gfsr_xor_keystream_cipher_unit_assert.svh @@
// Assertion macros used by the keystream cipher unit RTL.
`ifndef GFSR_XOR_KEYSTREAM_CIPHER_UNIT_ASSERT_SVH
`define GFSR_XOR_KEYSTREAM_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GXK_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gxk: implication check failed");

// Next-cycle implication, checked outside reset.
`define GXK_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gxk: next-cycle check failed");

`endif

@@ design/gxk_pkg.sv @@
// Types and constants of the GFSR keystream cipher.
`default_nettype none
package gxk_pkg;

  localparam int WORD_W      = 32;
  localparam int TABLE_WORDS = 521;
  localparam int TAB_AW      = $clog2(TABLE_WORDS);
  localparam int LAG_WORDS   = 32;
  localparam int MIX_BASE    = TABLE_WORDS - LAG_WORDS;
  localparam int SEED_WORDS  = 17;
  localparam int MIX_PASSES  = 3;
  localparam int LCG_BIT_W   = $clog2(WORD_W);
  localparam int LCG_WCNT_W  = $clog2(SEED_WORDS);
  localparam int SHL_BITS    = 23;
  localparam int SHR_BITS    = 9;

  // taps of the lag line, newest word at the top
  localparam int TAP_P1  = LAG_WORDS - 1;
  localparam int TAP_P16 = LAG_WORDS - 16;
  localparam int TAP_P17 = LAG_WORDS - 17;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [TAB_AW-1:0] tab_addr_t;

  localparam word_t     LCG_MULT      = 32'h5D588B65;
  localparam tab_addr_t LAST_ADDR     = tab_addr_t'(TABLE_WORDS - 1);
  localparam tab_addr_t MIX_BASE_ADDR = tab_addr_t'(MIX_BASE);

  localparam logic KIND_SETUP = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef struct packed {
    logic      we;
    tab_addr_t waddr;
    word_t     wdata;
    logic      re;
    tab_addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    word_t word;
  } lcg_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_EXT,
    ST_MIX_PRE,
    ST_MIX_RUN,
    ST_MIX_TAIL,
    ST_XOR
  } state_t;

endpackage
`default_nettype wire

@@ design/gxk_mem.sv @@
// Key table memory: one write port, one registered read port.
`default_nettype none
module gxk_mem (
  input  wire logic              clk,
  input  wire gxk_pkg::mem_req_t mreq,
  output gxk_pkg::word_t         rdata
);
  import gxk_pkg::*;

  word_t mem_r [0:TABLE_WORDS-1];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem_r[mreq.waddr] <= mreq.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rdata_r <= mem_r[mreq.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ design/gxk_lcg.sv @@
// LCG seed generator: one LCG step per cycle; each table word collects the top bit of successive steps.
`default_nettype none
module gxk_lcg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire gxk_pkg::word_t     seed,
  output gxk_pkg::lcg_word_t      lcg_w
);
  import gxk_pkg::*;

  localparam logic [LCG_BIT_W-1:0]  BIT_LAST  = LCG_BIT_W'(WORD_W - 1);
  localparam logic [LCG_WCNT_W-1:0] WORD_LAST = LCG_WCNT_W'(SEED_WORDS - 1);

  logic                  busy_r, busy_nxt;
  word_t                 s_r, s_nxt;
  word_t                 acc_r, acc_nxt;
  logic [LCG_BIT_W-1:0]  bit_r, bit_nxt;
  logic [LCG_WCNT_W-1:0] wcnt_r, wcnt_nxt;
  logic                  valid_r, valid_nxt;
  logic                  last_r;
  word_t                 word_r;

  word_t s_step;
  word_t acc_step;
  logic  word_end;
  logic  last_word;

  assign s_step    = word_t'(s_r * LCG_MULT) + word_t'(1);
  assign acc_step  = {s_step[WORD_W-1], acc_r[WORD_W-1:1]};
  assign word_end  = busy_r && (bit_r == BIT_LAST);
  assign last_word = (wcnt_r == WORD_LAST);

  always_comb begin
    busy_nxt  = busy_r;
    s_nxt     = s_r;
    acc_nxt   = acc_r;
    bit_nxt   = bit_r;
    wcnt_nxt  = wcnt_r;
    valid_nxt = word_end;
    if (start) begin
      busy_nxt = 1'b1;
      s_nxt    = seed;
      acc_nxt  = '0;
      bit_nxt  = '0;
      wcnt_nxt = '0;
    end else if (busy_r) begin
      s_nxt   = s_step;
      acc_nxt = acc_step;
      bit_nxt = bit_r + 1'b1;
      if (word_end) begin
        wcnt_nxt = wcnt_r + 1'b1;
        if (last_word) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      bit_r   <= '0;
      wcnt_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
      bit_r   <= bit_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    acc_r <= acc_nxt;
    if (word_end) begin
      word_r <= acc_step;
      last_r <= last_word;
    end
  end

  assign lcg_w.valid = valid_r;
  assign lcg_w.last  = last_r;
  assign lcg_w.word  = word_r;

endmodule
`default_nettype wire

@@ design/gfsr_xor_keystream_cipher_unit.sv @@
// Data item: key word read ahead of ST_XOR, result registered from there; no new item until idle.
// A data item that wraps the key position first runs a mix pass (32 preload reads,
// 521 read-modify-writes over the table memory, then the ST_MIX_TAIL drain state).
// Setup item: 544 LCG steps, 504 extension writes, three mix passes.
// Reset clears control state and the seed register; the key table holds no reset value.
`default_nettype none
`include "gfsr_xor_keystream_cipher_unit_assert.svh"
module gfsr_xor_keystream_cipher_unit (
  input  wire  logic                 clk,
  input  wire  logic                 rst_n,
  input  wire  logic                 cfg_wr_en,
  input  wire  gxk_pkg::word_t       cfg_wr_data,
  input  wire  logic                 in_valid,
  output logic                       in_stall,
  input  wire  logic                 in_kind,
  input  wire  gxk_pkg::word_t       in_data_word,
  input  wire  logic                 in_last_word,
  output logic                       out_valid,
  input  wire  logic                 out_stall,
  output gxk_pkg::word_t             out_result_word,
  output logic                       out_result_last
);
  import gxk_pkg::*;

  localparam logic [1:0] MIX_EXTRA = 2'(MIX_PASSES - 1);

  state_t     state_r, state_nxt;
  word_t      key_seed_r;
  tab_addr_t  pos_r, pos_nxt;
  tab_addr_t  addr_r, addr_nxt;
  logic [1:0] mix_left_r, mix_left_nxt;
  logic       mix_data_r, mix_data_nxt;
  logic       rtn_pre_r, rtn_run_r;
  tab_addr_t  rtn_addr_r;
  word_t      data_r;
  logic       last_r;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_word_r;
  logic       out_last_r;
  word_t      line_r [0:LAG_WORDS-1];

  logic      accept;
  logic      lcg_start;
  lcg_word_t lcg_w;
  mem_req_t  mreq;
  word_t     mem_rdata;
  logic      push;
  word_t     push_word;
  logic      out_load;
  word_t     seed_word;
  word_t     ext_word;
  word_t     mix_word;

  gxk_lcg u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lcg_start),
    .seed  (key_seed_r),
    .lcg_w (lcg_w)
  );

  gxk_mem u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (mem_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // word 16 folds in words 0 and 15; later words use lags 1, 16 and 17
  assign seed_word = lcg_w.last
                   ? ((line_r[TAP_P16] >> SHR_BITS) ^ (lcg_w.word << SHL_BITS) ^ line_r[TAP_P1])
                   : lcg_w.word;
  assign ext_word  = line_r[TAP_P1] ^ (line_r[TAP_P17] << SHL_BITS)
                   ^ (line_r[TAP_P16] >> SHR_BITS);
  assign mix_word  = mem_rdata ^ line_r[0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_SETUP) begin
            state_nxt = ST_SEED;
          end else if (pos_r == LAST_ADDR) begin
            state_nxt = ST_MIX_PRE;
          end else begin
            state_nxt = ST_XOR;
          end
        end
      end
      ST_SEED: begin
        if (lcg_w.valid && lcg_w.last) begin
          state_nxt = ST_EXT;
        end
      end
      ST_EXT: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_MIX_PRE;
        end
      end
      ST_MIX_PRE: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_MIX_RUN;
        end
      end
      ST_MIX_RUN: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_MIX_TAIL;
        end
      end
      ST_MIX_TAIL: begin
        if (mix_left_r != '0) begin
          state_nxt = ST_MIX_PRE;
        end else if (mix_data_r) begin
          state_nxt = ST_XOR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_XOR: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mreq      = '0;
    lcg_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r) inside
      ST_IDLE: begin
        lcg_start = accept && (in_kind == KIND_SETUP);
        if (accept && (in_kind == KIND_DATA) && (pos_r != LAST_ADDR)) begin
          mreq.re    = 1'b1;
          mreq.raddr = pos_r + 1'b1;
        end
      end
      ST_SEED: begin
        if (lcg_w.valid) begin
          mreq.we    = 1'b1;
          mreq.waddr = addr_r;
          mreq.wdata = seed_word;
        end
      end
      ST_EXT: begin
        mreq.we    = 1'b1;
        mreq.waddr = addr_r;
        mreq.wdata = ext_word;
      end
      ST_MIX_PRE, ST_MIX_RUN: begin
        mreq.re    = 1'b1;
        mreq.raddr = addr_r;
      end
      ST_MIX_TAIL: begin
        if ((mix_left_r == '0) && mix_data_r) begin
          mreq.re    = 1'b1;
          mreq.raddr = pos_r;
        end
      end
      ST_XOR: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        mreq = '0;
      end
    endcase
    // mix write-back lands in the cycle after its read
    if (rtn_run_r) begin
      mreq.we    = 1'b1;
      mreq.waddr = rtn_addr_r;
      mreq.wdata = mix_word;
    end
  end

  // lag line input
  always_comb begin
    push      = 1'b0;
    push_word = mix_word;
    if (rtn_run_r) begin
      push      = 1'b1;
      push_word = mix_word;
    end else if (rtn_pre_r) begin
      push      = 1'b1;
      push_word = mem_rdata;
    end else if (state_r == ST_EXT) begin
      push      = 1'b1;
      push_word = ext_word;
    end else if ((state_r == ST_SEED) && lcg_w.valid) begin
      push      = 1'b1;
      push_word = seed_word;
    end
  end

  // counters and flags
  always_comb begin
    pos_nxt      = pos_r;
    addr_nxt     = addr_r;
    mix_left_nxt = mix_left_r;
    mix_data_nxt = mix_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mix_data_nxt = (in_kind == KIND_DATA);
          if (in_kind == KIND_SETUP) begin
            pos_nxt      = LAST_ADDR;
            addr_nxt     = '0;
            mix_left_nxt = MIX_EXTRA;
          end else if (pos_r == LAST_ADDR) begin
            pos_nxt      = '0;
            addr_nxt     = MIX_BASE_ADDR;
            mix_left_nxt = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      ST_SEED: begin
        if (lcg_w.valid) begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_EXT: begin
        addr_nxt = (addr_r == LAST_ADDR) ? MIX_BASE_ADDR : addr_r + 1'b1;
      end
      ST_MIX_PRE: begin
        addr_nxt = (addr_r == LAST_ADDR) ? '0 : addr_r + 1'b1;
      end
      ST_MIX_RUN: begin
        if (addr_r != LAST_ADDR) begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_MIX_TAIL: begin
        if (mix_left_r != '0) begin
          mix_left_nxt = mix_left_r - 1'b1;
          addr_nxt     = MIX_BASE_ADDR;
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_seed_r  <= '0;
      pos_r       <= LAST_ADDR;
      addr_r      <= '0;
      mix_left_r  <= '0;
      mix_data_r  <= 1'b0;
      rtn_pre_r   <= 1'b0;
      rtn_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        key_seed_r <= cfg_wr_data;
      end
      pos_r       <= pos_nxt;
      addr_r      <= addr_nxt;
      mix_left_r  <= mix_left_nxt;
      mix_data_r  <= mix_data_nxt;
      rtn_pre_r   <= (state_r == ST_MIX_PRE);
      rtn_run_r   <= (state_r == ST_MIX_RUN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rtn_addr_r <= addr_r;
    if (accept) begin
      data_r <= in_data_word;
      last_r <= in_last_word;
    end
    if (out_load) begin
      out_word_r <= data_r ^ mem_rdata;
      out_last_r <= last_r;
    end
    if (push) begin
      for (int k = 0; k < LAG_WORDS - 1; k++) begin
        line_r[k] <= line_r[k+1];
      end
      line_r[LAG_WORDS-1] <= push_word;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;
  assign out_result_last = out_last_r;

  `GXK_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_r && out_stall, !out_load)
  `GXK_ASSERT_NXT(a_xor_holds, clk, rst_n,
                  (state_r == ST_XOR) && out_valid_r && out_stall, state_r == ST_XOR)
  `GXK_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, pos_r <= LAST_ADDR)
  `GXK_ASSERT_IMP(a_rw_apart, clk, rst_n, mreq.we && mreq.re, mreq.waddr != mreq.raddr)
  `GXK_ASSERT_IMP(a_pre_no_write, clk, rst_n, rtn_pre_r, !mreq.we)

endmodule
`default_nettype wire
